/* hdl/tscs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tscs_pkg;

    localparam int CountW = 30;
    localparam int ErrW   = 64;
    localparam int AmtW   = 48;
    localparam int StepW  = 47;
    localparam int LimW   = 31;
    localparam int ProdW  = 77;
    localparam int QuotW  = 30;

    localparam logic [CountW-1:0] COUNT_MAX = CountW'(1000000000);
    localparam logic [CountW-1:0] BATCH_MAX = CountW'(256);

    typedef struct packed {
        logic [CountW-1:0] first_count;
        logic [CountW-1:0] end_count;
        logic [CountW-1:0] seed_a;
        logic [CountW-1:0] seed_b;
        logic [ErrW-1:0]   seed_error;
    } req_t;

    typedef struct packed {
        logic [CountW-1:0] best_count_a;
        logic [CountW-1:0] best_count_b;
        logic [ErrW-1:0]   best_error;
        logic              status;
    } res_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     go;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic done;
    } unit_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_ONE,
        ST_CHK_TWO,
        ST_LOOP,
        ST_MUL_A,
        ST_DIV,
        ST_MUL_B,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        REG_TARGET,
        REG_STEP_ONE,
        REG_STEP_TWO,
        REG_SUM_LIMIT
    } reg_idx_t;

endpackage

`default_nettype wire

/* hdl/tscs_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared arithmetic unit: a 30 by 47 bit product in two 24-bit partial
// products, or a 30-bit quotient by restoring division, one bit a cycle.
module tscs_unit
    import tscs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire unit_cmd_t         cmd,
    input  wire logic [CountW-1:0] mul_x,
    input  wire logic [StepW-1:0]  mul_y,
    input  wire logic [AmtW-1:0]   div_n,
    input  wire logic [StepW-1:0]  div_d,
    output unit_sts_t              sts,
    output logic [ProdW-1:0]       prod,
    output logic [QuotW-1:0]       quot,
    output logic                   rem_nz
);

    logic              busy_reg;
    logic              done_reg;
    unit_op_t          op_reg;
    logic [4:0]        cnt_reg;
    logic [CountW-1:0] x_reg;
    logic [StepW-1:0]  y_reg;
    logic [53:0]       pp_reg;
    logic [ProdW-1:0]  acc_reg;
    logic [AmtW-1:0]   r_reg;
    logic [QuotW-1:0]  dvd_reg;
    logic [QuotW-1:0]  q_reg;
    logic [StepW-1:0]  d_reg;

    logic [23:0]       chunk;
    logic [53:0]       pp_w;
    logic [77:0]       pp_shift;
    logic [AmtW-1:0]   trial;
    logic              ge;

    assign chunk    = (cnt_reg == 5'd0) ? y_reg[23:0] : {1'b0, y_reg[46:24]};
    assign pp_w     = x_reg * chunk;
    assign pp_shift = {pp_reg, 24'd0};
    assign trial    = {r_reg[AmtW-2:0], dvd_reg[QuotW-1]};
    assign ge       = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= 5'd0;
        end
        else if (cmd.go)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            op_reg   <= cmd.op;
            cnt_reg  <= 5'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if ((op_reg == OP_MUL && cnt_reg == 5'd2) ||
                (op_reg == OP_DIV && cnt_reg == 5'(QuotW - 1)))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            x_reg   <= mul_x;
            y_reg   <= mul_y;
            r_reg   <= {{QuotW{1'b0}}, div_n[AmtW-1:QuotW]};
            dvd_reg <= div_n[QuotW-1:0];
            d_reg   <= div_d;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                case (cnt_reg)
                    5'd0:
                    begin
                        pp_reg <= pp_w;
                    end
                    5'd1:
                    begin
                        acc_reg <= {23'd0, pp_reg};
                        pp_reg  <= pp_w;
                    end
                    default:
                    begin
                        acc_reg <= acc_reg + pp_shift[ProdW-1:0];
                    end
                endcase
            end
            else
            begin
                r_reg   <= ge ? (trial - {1'b0, d_reg}) : trial;
                q_reg   <= {q_reg[QuotW-2:0], ge};
                dvd_reg <= {dvd_reg[QuotW-2:0], 1'b0};
            end
        end
    end

    assign sts.done = done_reg;
    assign prod     = acc_reg;
    assign quot     = q_reg;
    assign rem_nz   = (r_reg != '0);

endmodule

`default_nettype wire

/* hdl/two_step_combination_search.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-step combination search. A word on request, taken when start is high
// and busy is low, names a range of counts a (at most 256) and a seed pair
// with its error. For each a the block forms b as the floor and the ceiling
// of (target - a*step_one)/step_two (zero once a*step_one reaches the target),
// clamps it to the sum limit, and keeps the pair of least absolute error, the
// smaller a+b winning a tie. One result word appears on result for exactly
// one cycle with done high; the receiver cannot stall it, so it must take it
// in that cycle. A request that breaks the bounds is answered with status 1
// and the seed echoed. All work runs through one shared multiply and divide
// unit, the 30-step divider being the larger share; busy stays high until the
// result is given. Configuration is written through cfg_write, cfg_index and
// cfg_data while the block is idle; the block itself does not enforce this,
// so the user must keep to it.
module two_step_combination_search
    import tscs_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire req_t            request,
    output logic                 done,
    output res_t                 result,
    input  wire logic            cfg_write,
    input  wire reg_idx_t        cfg_index,
    input  wire logic [AmtW-1:0] cfg_data
);

    // Configuration registers.
    logic signed [AmtW-1:0] target_reg;
    logic [StepW-1:0]       step_one_reg;
    logic [StepW-1:0]       step_two_reg;
    logic signed [LimW-1:0] sum_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            step_one_reg  <= StepW'(1);
            step_two_reg  <= StepW'(1);
            sum_limit_reg <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET:    target_reg    <= cfg_data;
                REG_STEP_ONE:  step_one_reg  <= cfg_data[StepW-1:0];
                REG_STEP_TWO:  step_two_reg  <= cfg_data[StepW-1:0];
                REG_SUM_LIMIT: sum_limit_reg <= cfg_data[LimW-1:0];
                default:       ;
            endcase
        end
    end

    // Magnitude of the target; the most negative value still fits unsigned.
    logic            target_neg;
    logic            target_pos;
    logic [AmtW-1:0] tmag;

    assign target_neg = target_reg[AmtW-1];
    assign target_pos = !target_neg && (target_reg != '0);
    assign tmag       = target_neg ? (AmtW'(0) - target_reg) : target_reg;

    // Bounds that can be judged at once from the request and the registers.
    logic limit_on;
    logic quick_reject;

    assign limit_on = !sum_limit_reg[LimW-1];

    always_comb
    begin
        quick_reject = 1'b0;
        if (step_one_reg == '0 || step_two_reg == '0)
            quick_reject = 1'b1;
        if (request.end_count < request.first_count)
            quick_reject = 1'b1;
        else if ((request.end_count - request.first_count) > BATCH_MAX)
            quick_reject = 1'b1;
        if (request.end_count > COUNT_MAX)
            quick_reject = 1'b1;
        if (sum_limit_reg[LimW-1] && sum_limit_reg != '1)
            quick_reject = 1'b1;
        if (limit_on && sum_limit_reg[CountW-1:0] > COUNT_MAX)
            quick_reject = 1'b1;
        if (limit_on && {1'b0, request.end_count} >
            ({1'b0, sum_limit_reg[CountW-1:0]} + 31'd1))
            quick_reject = 1'b1;
        if (request.seed_a > COUNT_MAX || request.seed_b > COUNT_MAX)
            quick_reject = 1'b1;
    end

    // Shared unit.
    unit_cmd_t         cmd;
    unit_sts_t         sts;
    logic [CountW-1:0] mul_x;
    logic [StepW-1:0]  mul_y;
    logic [ProdW-1:0]  prod;
    logic [QuotW-1:0]  quot;
    logic              rem_nz;

    state_t            state_reg;
    state_t            state_next;
    logic              pend_reg;
    logic              unit_done;

    logic [CountW-1:0] a_reg;
    logic [CountW-1:0] end_reg;
    logic [CountW-1:0] best_a_reg;
    logic [CountW-1:0] best_b_reg;
    logic [ErrW-1:0]   best_e_reg;
    logic              status_reg;
    logic [AmtW-1:0]   rem_reg;
    logic              pos_reg;
    logic [CountW-1:0] b_reg;
    logic [CountW-1:0] hi_reg;
    logic              two_reg;
    logic              cand_reg;
    logic [ErrW-1:0]   e_reg;

    tscs_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .mul_x  (mul_x),
        .mul_y  (mul_y),
        .div_n  (rem_reg),
        .div_d  (step_two_reg),
        .sts    (sts),
        .prod   (prod),
        .quot   (quot),
        .rem_nz (rem_nz)
    );

    assign unit_done = pend_reg && sts.done;

    // Values formed when the unit hands back a product or a quotient.
    logic [ErrW-1:0]   p1_sat;
    logic [ErrW:0]     e_sum;
    logic [ErrW-1:0]   e_flat;
    logic              pos_now;
    logic [CountW-1:0] cap;
    logic [CountW-1:0] lo_raw;
    logic [CountW-1:0] hi_raw;
    logic [CountW-1:0] lo_cl;
    logic [CountW-1:0] hi_cl;
    logic [48:0]       pb;
    logic [48:0]       e_b;
    logic [CountW:0]   sum_new;
    logic [CountW:0]   sum_best;
    logic              better;

    assign p1_sat  = (prod[ProdW-1:ErrW] != '0) ? '1 : prod[ErrW-1:0];
    assign e_sum   = {1'b0, p1_sat} + {{(ErrW - AmtW + 1){1'b0}}, tmag};
    assign e_flat  = target_neg ? (e_sum[ErrW] ? '1 : e_sum[ErrW-1:0])
                                : (p1_sat - {{(ErrW - AmtW){1'b0}}, tmag});
    assign pos_now = target_pos && (prod < {{(ProdW - AmtW){1'b0}}, tmag});

    assign cap    = sum_limit_reg[CountW-1:0] - a_reg;
    assign lo_raw = quot;
    assign hi_raw = quot + {{(CountW - 1){1'b0}}, rem_nz};
    assign lo_cl  = (limit_on && lo_raw > cap) ? cap : lo_raw;
    assign hi_cl  = (limit_on && hi_raw > cap) ? cap : hi_raw;

    assign pb  = prod[48:0];
    assign e_b = (pb >= {1'b0, rem_reg}) ? (pb - {1'b0, rem_reg})
                                         : ({1'b0, rem_reg} - pb);

    assign sum_new  = {1'b0, a_reg} + {1'b0, b_reg};
    assign sum_best = {1'b0, best_a_reg} + {1'b0, best_b_reg};
    assign better   = (e_reg < best_e_reg) ||
                      (e_reg == best_e_reg && sum_new < sum_best);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = quick_reject ? ST_DONE : ST_CHK_ONE;
            end
            ST_CHK_ONE:
            begin
                if (unit_done)
                    state_next = ({{(ProdW - AmtW){1'b0}}, tmag} > prod)
                                 ? ST_DONE : ST_CHK_TWO;
            end
            ST_CHK_TWO:
            begin
                if (unit_done)
                    state_next = ({{(ProdW - AmtW){1'b0}}, tmag} > prod)
                                 ? ST_DONE : ST_LOOP;
            end
            ST_LOOP:
            begin
                state_next = (a_reg == end_reg) ? ST_DONE : ST_MUL_A;
            end
            ST_MUL_A:
            begin
                if (unit_done)
                    state_next = pos_now ? ST_DIV : ST_CMP;
            end
            ST_DIV:
            begin
                if (unit_done)
                    state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                if (unit_done)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = (pos_reg && !cand_reg && two_reg) ? ST_MUL_B : ST_LOOP;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        cmd.go = 1'b0;
        cmd.op = OP_MUL;
        mul_x  = COUNT_MAX;
        mul_y  = step_one_reg;
        case (state_reg)
            ST_CHK_ONE:
            begin
                cmd.go = !pend_reg;
            end
            ST_CHK_TWO:
            begin
                cmd.go = !pend_reg;
                mul_y  = step_two_reg;
            end
            ST_MUL_A:
            begin
                cmd.go = !pend_reg;
                mul_x  = a_reg;
            end
            ST_DIV:
            begin
                cmd.go = !pend_reg;
                cmd.op = OP_DIV;
            end
            ST_MUL_B:
            begin
                cmd.go = !pend_reg;
                mul_x  = b_reg;
                mul_y  = step_two_reg;
            end
            default:
            begin
                cmd.go = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign result.best_count_a = best_a_reg;
    assign result.best_count_b = best_b_reg;
    assign result.best_error   = best_e_reg;
    assign result.status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.go)
                pend_reg <= 1'b1;
            else if (sts.done)
                pend_reg <= 1'b0;
        end
    end

    // Datapath of the search.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_reg      <= request.first_count;
                    end_reg    <= request.end_count;
                    best_a_reg <= request.seed_a;
                    best_b_reg <= request.seed_b;
                    best_e_reg <= request.seed_error;
                    status_reg <= quick_reject;
                end
            end
            ST_CHK_ONE, ST_CHK_TWO:
            begin
                if (unit_done && {{(ProdW - AmtW){1'b0}}, tmag} > prod)
                    status_reg <= 1'b1;
            end
            ST_MUL_A:
            begin
                if (unit_done)
                begin
                    pos_reg  <= pos_now;
                    rem_reg  <= tmag - prod[AmtW-1:0];
                    e_reg    <= e_flat;
                    b_reg    <= '0;
                    cand_reg <= 1'b0;
                    two_reg  <= 1'b0;
                end
            end
            ST_DIV:
            begin
                if (unit_done)
                begin
                    b_reg    <= lo_cl;
                    hi_reg   <= hi_cl;
                    two_reg  <= (lo_cl != hi_cl);
                    cand_reg <= 1'b0;
                end
            end
            ST_MUL_B:
            begin
                if (unit_done)
                    e_reg <= {{(ErrW - 49){1'b0}}, e_b};
            end
            ST_CMP:
            begin
                if (better)
                begin
                    best_a_reg <= a_reg;
                    best_b_reg <= b_reg;
                    best_e_reg <= e_reg;
                end
                if (pos_reg && !cand_reg && two_reg)
                begin
                    cand_reg <= 1'b1;
                    b_reg    <= hi_reg;
                end
                else
                begin
                    a_reg <= a_reg + CountW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
